// File: sv/tccs_pkg.sv
// Shared types and constants for the text console with cursor and scrolling.
// Holds the command codes, the transaction structs and the blank cell value.
// No dependencies.
package tccs_pkg;

   // Field widths of the transactions, fixed by the interface.
   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int COLUMN_W  = 7;
   localparam int ROW_W     = 5;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   // Command codes carried in the request.
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_PRINT  = 2'd1,
      CMD_CURSOR = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // Character values with a special meaning.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h00;
   localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;

   // A cell holds the attribute in the high byte and the character in the low byte.
   localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

   typedef struct packed {
      cmd_type               command;
      logic [CHAR_W-1:0]     char_code;
      logic [ATTR_W-1:0]     attribute;
      logic [COLUMN_W-1:0]   column;
      logic [ROW_W-1:0]      row;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]     cell_char;
      logic [ATTR_W-1:0]     cell_attribute;
      logic [COLUMN_W-1:0]   cursor_column;
      logic [ROW_W-1:0]      cursor_row;
   } rsp_type;

endpackage

// File: sv/tccs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the character cell store of the console. No dependencies.
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/text_console_cursor_scroll.sv
// Top level of the text console: cell store, cursor, row rotation and sequencer.
// Depends on tccs_pkg and tccs_ram.
//
//  Channel  Direction  Ports                           Contents
//  req      in         req_valid, req_stall, req_data  command with character, attribute, position
//  rsp      out        rsp_valid, rsp_stall, rsp_data  cell read back and cursor after the command
//
// In the accepting cycle a command drives the single cell address unit and the RAM port;
// the finish state then delivers the result into the output register once it is free.
// A print that runs past the last row first blanks the new bottom row in the blank state;
// rows are rotated, so no cell is copied.
// After reset a clearing pass writes the blank cell to all COLUMNS*ROWS entries
// with req_stall high.
// A stalled result holds in the output register; the next command is still taken meanwhile.
module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int LINE_W = $clog2(ROWS);
   localparam int SUM_W  = LINE_W + 1;
   localparam int DEPTH  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_BLANK  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    cursor_col_ff, cursor_col_in;
   logic [LINE_W-1:0]   cursor_line_ff, cursor_line_in;
   logic [LINE_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [COL_W-1:0]    blank_col_ff, blank_col_in;
   logic [LINE_W-1:0]   blank_line_ff, blank_line_in;
   logic                read_hit_ff, read_hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic                on_screen;
   logic                is_newline;
   logic                col_last;
   logic                line_last;
   logic                col_sat;
   logic                line_sat;
   logic [COL_W-1:0]    req_col;
   logic [LINE_W-1:0]   req_line;
   logic                out_free;

   logic                map_en;
   logic [LINE_W-1:0]   au_line;
   logic [COL_W-1:0]    au_col;
   logic [SUM_W-1:0]    line_sum;
   logic [LINE_W-1:0]   phys_line;
   logic [ADDR_W-1:0]   mem_addr;

   logic                wr_en;
   logic [CELL_W-1:0]   wr_data;
   logic                rd_en;
   logic [CELL_W-1:0]   rd_data;

   // Request decode.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && (state_ff == ST_IDLE);
   assign col_sat    = (32'(req_data.column) >= 32'(COLUMNS));
   assign line_sat   = (32'(req_data.row) >= 32'(ROWS));
   assign on_screen  = !col_sat && !line_sat;
   assign req_col    = COL_W'(req_data.column);
   assign req_line   = LINE_W'(req_data.row);
   assign is_newline = (req_data.char_code == NEWLINE_CODE);
   assign col_last   = (cursor_col_ff == COL_W'(COLUMNS - 1));
   assign line_last  = (cursor_line_ff == LINE_W'(ROWS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the shared address unit.
   always_comb begin
      map_en  = 1'b1;
      au_line = req_line;
      au_col  = req_col;
      case (state_ff)
         ST_BLANK: begin
            map_en  = 1'b0;
            au_line = blank_line_ff;
            au_col  = blank_col_ff;
         end
         default: begin
            if (req_data.command == CMD_PRINT) begin
               au_line = cursor_line_ff;
               au_col  = cursor_col_ff;
            end
         end
      endcase
   end

   // Address unit: row rotated by top (raw when blanking) * COLUMNS + column; clear_addr in clear.
   always_comb begin
      line_sum = {1'b0, au_line} + {1'b0, top_ff};
      if (line_sum >= SUM_W'(ROWS)) begin
         line_sum = line_sum - SUM_W'(ROWS);
      end
      phys_line = map_en ? LINE_W'(line_sum) : au_line;
      if (state_ff == ST_CLEAR) begin
         mem_addr = clear_addr_ff;
      end else begin
         mem_addr = ADDR_W'(phys_line) * ADDR_W'(COLUMNS) + ADDR_W'(au_col);
      end
   end

   // Memory port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_data = BLANK_CELL;
      rd_en   = 1'b0;
      case (state_ff)
         ST_CLEAR, ST_BLANK: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            wr_data = {req_data.attribute, req_data.char_code};
            if (req_fire) begin
               case (req_data.command)
                  CMD_WRITE:  wr_en = on_screen;
                  CMD_PRINT:  wr_en = !is_newline;
                  CMD_READ:   rd_en = on_screen;
                  default:    wr_en = 1'b0;
               endcase
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mem_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Sequencer and cursor update.
   always_comb begin
      state_in       = state_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_line_in = cursor_line_ff;
      top_in         = top_ff;
      clear_addr_in  = clear_addr_ff;
      blank_col_in   = blank_col_ff;
      blank_line_in  = blank_line_ff;
      read_hit_in    = read_hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_FINISH;
               read_hit_in = (req_data.command == CMD_READ) && on_screen;
               case (req_data.command)
                  CMD_PRINT: begin
                     if (is_newline || col_last) begin
                        cursor_col_in = '0;
                        if (line_last) begin
                           // Scroll: the old top row becomes the new, blanked bottom row.
                           blank_line_in = top_ff;
                           blank_col_in  = '0;
                           top_in        = (top_ff == LINE_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                           state_in      = ST_BLANK;
                        end else begin
                           cursor_line_in = cursor_line_ff + 1'b1;
                        end
                     end else begin
                        cursor_col_in = cursor_col_ff + 1'b1;
                     end
                  end
                  CMD_CURSOR: begin
                     cursor_col_in  = col_sat ? COL_W'(COLUMNS - 1) : req_col;
                     cursor_line_in = line_sat ? LINE_W'(ROWS - 1) : req_line;
                  end
                  default: begin
                     cursor_col_in = cursor_col_ff;
                  end
               endcase
            end
         end
         ST_BLANK: begin
            blank_col_in = blank_col_ff + 1'b1;
            if (blank_col_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.cell_char         = read_hit_ff ? rd_data[CHAR_W-1:0] : '0;
               rsp_in.cell_attribute    = read_hit_ff ? rd_data[CELL_W-1:CHAR_W] : '0;
               rsp_in.cursor_column     = COLUMN_W'(cursor_col_ff);
               rsp_in.cursor_row        = ROW_W'(cursor_line_ff);
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cursor_col_ff  <= '0;
         cursor_line_ff <= '0;
         top_ff         <= '0;
         clear_addr_ff  <= '0;
         blank_col_ff   <= '0;
         read_hit_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_line_ff <= cursor_line_in;
         top_ff         <= top_in;
         clear_addr_ff  <= clear_addr_in;
         blank_col_ff   <= blank_col_in;
         read_hit_ff    <= read_hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      blank_line_ff <= blank_line_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
